// ===== hw/rtl/rpd_pkg.sv =====
package rpd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_CK1  = 2'd2,
    PH_CK2  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD   = 3'd0,
    EV_ACCEPT    = 3'd1,
    EV_REJECT    = 3'd2,
    EV_RESTART   = 3'd3,
    EV_INTERRUPT = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    ACK_NONE  = 2'd0,
    ACK_PLUS  = 2'd1,
    ACK_MINUS = 2'd2
  } ack_t;

  localparam logic [7:0] CH_START  = 8'h24;
  localparam logic [7:0] CH_CKSUM  = 8'h23;
  localparam logic [7:0] CH_ESCAPE = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] CH_INTR   = 8'h03;

  typedef struct packed {
    phase_t      phase;
    logic        esc_pend;
    logic [7:0]  run_sum;
    logic [7:0]  rcv_sum;
  } frame_st_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  data;
    ack_t        ack;
  } result_t;

endpackage

// ===== hw/rtl/rpd_step.sv =====
module rpd_step
  import rpd_pkg::*;
(
  input  frame_st_t   st,
  input  logic [7:0]  rx_byte,
  input  logic        noack,
  output frame_st_t   st_nxt,
  output logic        res_valid,
  output result_t     res
);

  // Returns {digit_ok, digit_value}.
  function automatic logic [4:0] hex_lookup(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  logic [4:0] hex;
  logic       hex_ok;
  logic [3:0] hex_val;
  ack_t       ack_good;
  ack_t       ack_bad;

  assign hex     = hex_lookup(rx_byte);
  assign hex_ok  = hex[4];
  assign hex_val = hex[3:0];
  assign ack_good = noack ? ACK_NONE : ACK_PLUS;
  assign ack_bad  = noack ? ACK_NONE : ACK_MINUS;

  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    res.ev    = EV_PAYLOAD;
    res.data  = 8'h00;
    res.ack   = ACK_NONE;
    unique case (st.phase)
      PH_IDLE: begin
        if (rx_byte == CH_START) begin
          st_nxt.phase    = PH_DATA;
          st_nxt.run_sum  = 8'h00;
          st_nxt.esc_pend = 1'b0;
        end else if (rx_byte == CH_INTR) begin
          res_valid = 1'b1;
          res.ev    = EV_INTERRUPT;
        end
      end
      PH_DATA: begin
        priority if (!st.esc_pend && rx_byte == CH_START) begin
          st_nxt.run_sum  = 8'h00;
          st_nxt.esc_pend = 1'b0;
          res_valid       = 1'b1;
          res.ev          = EV_RESTART;
        end else if (!st.esc_pend && rx_byte == CH_CKSUM) begin
          st_nxt.phase   = PH_CK1;
          st_nxt.rcv_sum = 8'h00;
        end else begin
          // The escape character itself counts toward the checksum.
          st_nxt.run_sum = st.run_sum + rx_byte;
          if (!st.esc_pend && rx_byte == CH_ESCAPE) begin
            st_nxt.esc_pend = 1'b1;
          end else begin
            st_nxt.esc_pend = 1'b0;
            res_valid       = 1'b1;
            res.data        = st.esc_pend ? (rx_byte ^ ESC_XOR) : rx_byte;
          end
        end
      end
      PH_CK1: begin
        if (!hex_ok) begin
          st_nxt.phase = PH_IDLE;
          res_valid    = 1'b1;
          res.ev       = EV_REJECT;
          res.ack      = ack_bad;
        end else begin
          st_nxt.rcv_sum = {hex_val, 4'h0};
          st_nxt.phase   = PH_CK2;
        end
      end
      PH_CK2: begin
        st_nxt.phase = PH_IDLE;
        res_valid    = 1'b1;
        if (!hex_ok) begin
          res.ev  = EV_REJECT;
          res.ack = ack_bad;
        end else begin
          st_nxt.rcv_sum = {st.rcv_sum[7:4], hex_val};
          if ({st.rcv_sum[7:4], hex_val} == st.run_sum) begin
            res.ev  = EV_ACCEPT;
            res.ack = ack_good;
          end else begin
            res.ev  = EV_REJECT;
            res.ack = ack_bad;
          end
        end
      end
      default: begin
        st_nxt.phase = PH_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rsp_packet_deframer.sv =====
// Channel  Direction  Ports
// -------  ---------  ------------------------------------------------
// in       input      in_valid, in_stall, in_rx_byte
// out      output     out_valid, out_stall, out_event_res,
//                     out_payload_byte, out_ack_send
// cfg      input      cfg_we, cfg_wdata (no-ack mode)
//
// One byte is accepted per cycle while in_stall is low. A byte is held in the input
// register, is decoded against the frame state and its result lands in the output
// register, from which it is offered on the out channel. Bytes with no result
// still advance the frame state. A stalled result holds the decode stage; an
// empty input register still takes one byte, then the input stalls until the
// result transfers. Synchronous active-low reset returns to idle, no-ack off.
module rsp_packet_deframer
  import rpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_ack_send,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       noack_r;
  frame_st_t  st_r;
  frame_st_t  st_nxt;
  logic       res_valid;
  result_t    res;
  logic       out_valid_r;
  result_t    out_r;
  logic       advance;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  rpd_step u_step (
    .st        (st_r),
    .rx_byte   (in_byte_r),
    .noack     (noack_r),
    .st_nxt    (st_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      noack_r          <= 1'b0;
      st_r.phase       <= PH_IDLE;
      st_r.esc_pend    <= 1'b0;
      st_r.run_sum     <= 8'h00;
      st_r.rcv_sum     <= 8'h00;
    end else begin
      if (cfg_we) begin
        noack_r <= cfg_wdata;
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r && res_valid;
        if (in_valid_r) begin
          st_r <= st_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
    if (advance && in_valid_r && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_r.ev;
  assign out_payload_byte = out_r.data;
  assign out_ack_send     = out_r.ack;

  // Only verdicts carry an ack or nak.
  a_ack_only_on_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.ev != EV_ACCEPT && out_r.ev != EV_REJECT
    |-> out_r.ack == ACK_NONE)
    else $error("ack or nak on a non-verdict event");

  a_noack_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && noack_r |-> out_r.ack == ACK_NONE)
    else $error("ack or nak sent in no-ack mode");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.ev != EV_PAYLOAD |-> out_r.data == 8'h00)
    else $error("payload byte set on a non-payload event");

  // A verdict always sends the framer back to idle.
  a_verdict_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_valid_r && res_valid
    && (res.ev == EV_ACCEPT || res.ev == EV_REJECT)
    |=> st_r.phase == PH_IDLE)
    else $error("framer not idle after a verdict");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
  import rpd_pkg::*;
();

  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_FIXED = 2'd2
  } row_chk_t;

  typedef struct {
    logic [7:0] rx;
    row_chk_t   chk;
    result_t    want;
  } dir_row_t;

  localparam int HOLD_CYCLES = 150;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_event_res;
  logic [7:0] out_payload_byte;
  logic [1:0] out_ack_send;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;

  // How the transfer currently on the input is to be checked.
  row_chk_t drv_chk = CHK_MODEL;
  result_t  drv_want = '0;

  int tx_gap_max = 6;
  int rx_idle_max = 6;
  bit rx_hold_req = 1'b0;
  int mismatch_cnt = 0;

  // Shadow of the framer state and the no-ack register.
  phase_t     fr_phase = PH_IDLE;
  logic       fr_esc = 1'b0;
  logic [7:0] fr_run_sum = 8'h00;
  logic [7:0] fr_rcv_sum = 8'h00;
  logic       ack_off = 1'b0;

  result_t pending_events [$];

  dir_row_t dir_tab [0:24] = '{
    '{8'h41, CHK_NONE,  '0},
    '{8'h2B, CHK_NONE,  '0},
    '{8'h03, CHK_FIXED, '{EV_INTERRUPT, 8'h00, ACK_NONE}},
    '{8'h24, CHK_NONE,  '0},
    '{8'h00, CHK_FIXED, '{EV_PAYLOAD, 8'h00, ACK_NONE}},
    '{8'hFF, CHK_FIXED, '{EV_PAYLOAD, 8'hFF, ACK_NONE}},
    '{8'h7D, CHK_NONE,  '0},
    '{8'h24, CHK_FIXED, '{EV_PAYLOAD, 8'h04, ACK_NONE}},
    '{8'h7D, CHK_NONE,  '0},
    '{8'h23, CHK_FIXED, '{EV_PAYLOAD, 8'h03, ACK_NONE}},
    '{8'h7D, CHK_NONE,  '0},
    '{8'h7D, CHK_FIXED, '{EV_PAYLOAD, 8'h5D, ACK_NONE}},
    '{8'h23, CHK_NONE,  '0},
    '{8'h33, CHK_NONE,  '0},
    '{8'h61, CHK_FIXED, '{EV_ACCEPT, 8'h00, ACK_PLUS}},
    '{8'h24, CHK_NONE,  '0},
    '{8'h78, CHK_MODEL, '0},
    '{8'h24, CHK_FIXED, '{EV_RESTART, 8'h00, ACK_NONE}},
    '{8'h41, CHK_MODEL, '0},
    '{8'h23, CHK_NONE,  '0},
    '{8'h47, CHK_FIXED, '{EV_REJECT, 8'h00, ACK_MINUS}},
    '{8'h24, CHK_NONE,  '0},
    '{8'h23, CHK_NONE,  '0},
    '{8'h30, CHK_NONE,  '0},
    '{8'h67, CHK_FIXED, '{EV_REJECT, 8'h00, ACK_MINUS}}
  };

  rsp_packet_deframer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_payload_byte (out_payload_byte),
    .out_ack_send     (out_ack_send),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic hex_nibble(input logic [7:0] b, output logic [3:0] n);
    n = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      n = 4'(b - 8'h30);
      return 1'b1;
    end
    if (b >= 8'h61 && b <= 8'h66) begin
      n = 4'(b - 8'h61 + 8'd10);
      return 1'b1;
    end
    if (b >= 8'h41 && b <= 8'h46) begin
      n = 4'(b - 8'h41 + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic ack_t verdict_ack(input logic good);
    if (ack_off) return ACK_NONE;
    return good ? ACK_PLUS : ACK_MINUS;
  endfunction

  // Advances the shadow framer by one byte; returns 1 when the byte yields a result.
  function automatic logic deframe_byte(input logic [7:0] b, output result_t r);
    logic [3:0] nib;
    logic       ok;
    r = '0;
    case (fr_phase)
      PH_IDLE: begin
        if (b == CH_START) begin
          fr_phase = PH_DATA;
          fr_run_sum = 8'h00;
          fr_esc = 1'b0;
          return 1'b0;
        end
        if (b == CH_INTR) begin
          r = '{EV_INTERRUPT, 8'h00, ACK_NONE};
          return 1'b1;
        end
        return 1'b0;
      end
      PH_DATA: begin
        if (!fr_esc && b == CH_START) begin
          fr_run_sum = 8'h00;
          r = '{EV_RESTART, 8'h00, ACK_NONE};
          return 1'b1;
        end
        if (!fr_esc && b == CH_CKSUM) begin
          fr_phase = PH_CK1;
          fr_rcv_sum = 8'h00;
          return 1'b0;
        end
        fr_run_sum = fr_run_sum + b;
        if (!fr_esc && b == CH_ESCAPE) begin
          fr_esc = 1'b1;
          return 1'b0;
        end
        r = '{EV_PAYLOAD, fr_esc ? (b ^ ESC_XOR) : b, ACK_NONE};
        fr_esc = 1'b0;
        return 1'b1;
      end
      PH_CK1: begin
        ok = hex_nibble(b, nib);
        if (!ok) begin
          fr_phase = PH_IDLE;
          r = '{EV_REJECT, 8'h00, verdict_ack(1'b0)};
          return 1'b1;
        end
        fr_rcv_sum = {nib, 4'h0};
        fr_phase = PH_CK2;
        return 1'b0;
      end
      default: begin
        ok = hex_nibble(b, nib);
        fr_phase = PH_IDLE;
        if (!ok) begin
          r = '{EV_REJECT, 8'h00, verdict_ack(1'b0)};
          return 1'b1;
        end
        fr_rcv_sum = {fr_rcv_sum[7:4], nib};
        if (fr_rcv_sum == fr_run_sum) r = '{EV_ACCEPT, 8'h00, verdict_ack(1'b1)};
        else r = '{EV_REJECT, 8'h00, verdict_ack(1'b0)};
        return 1'b1;
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h, want %0h at %0t ns", what, got, want, $time);
    mismatch_cnt++;
  endtask

  // Checks output transfers first, then predicts from the input transfer of the same edge.
  always @(posedge clk) begin : monitor
    result_t r;
    logic    has;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          flag_mismatch("result with nothing pending", int'(out_event_res), 0);
        end else begin
          r = pending_events.pop_front();
          if (out_event_res != r.ev)
            flag_mismatch("event_res", int'(out_event_res), int'(r.ev));
          if (out_payload_byte != r.data)
            flag_mismatch("payload_byte", int'(out_payload_byte), int'(r.data));
          if (out_ack_send != r.ack)
            flag_mismatch("ack_send", int'(out_ack_send), int'(r.ack));
        end
      end
      if (cfg_we) ack_off = cfg_wdata;
      if (in_valid && !in_stall) begin
        has = deframe_byte(in_rx_byte, r);
        if (drv_chk == CHK_FIXED) pending_events.push_back(drv_want);
        else if (drv_chk == CHK_MODEL && has) pending_events.push_back(r);
      end
    end
  end

  // Result side: a random hold before each transfer, and one long hold on request.
  initial begin : receiver
    int hold;
    wait (rst_n);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end else begin
        hold = $urandom_range(0, rx_idle_max);
      end
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input row_chk_t chk, input result_t want);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    drv_chk <= chk;
    drv_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] b;
    logic [3:0] n;
    do b = 8'($urandom); while (hex_nibble(b, n));
    return b;
  endfunction

  // Mostly well-formed packets, with escapes, restarts and some broken checksums.
  task automatic send_random_packet(inout int sent);
    logic [7:0] pkt [$];
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] hi;
    logic [7:0] lo;
    int         len;
    int         mode;
    pkt.push_back(CH_START);
    sum = 8'h00;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        pkt.push_back(CH_START);
        sum = 8'h00;
      end
      if ($urandom_range(0, 7) == 0) begin
        b = 8'($urandom);
        pkt.push_back(CH_ESCAPE);
        pkt.push_back(b);
        sum = sum + CH_ESCAPE + b;
      end else begin
        do b = 8'($urandom); while (b == CH_START || b == CH_CKSUM || b == CH_ESCAPE);
        pkt.push_back(b);
        sum = sum + b;
      end
    end
    pkt.push_back(CH_CKSUM);
    mode = $urandom_range(0, 9);
    if (mode == 0) sum = sum ^ (8'h01 << $urandom_range(0, 7));
    hi = (mode == 1) ? non_hex_char() : hex_char(sum[7:4]);
    lo = (mode == 2) ? non_hex_char() : hex_char(sum[3:0]);
    pkt.push_back(hi);
    pkt.push_back(lo);
    foreach (pkt[i]) send_byte(pkt[i], CHK_MODEL, '0);
    sent += pkt.size();
  endtask

  // Bytes between packets: interrupts, stray acks and arbitrary values.
  task automatic send_noise();
    logic [7:0] b;
    int         n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: b = CH_INTR;
        1: b = 8'h2B;
        2: b = 8'h2D;
        default: b = 8'($urandom);
      endcase
      send_byte(b, CHK_MODEL, '0);
    end
  endtask

  task automatic random_phase(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_random_packet(sent);
    end
  endtask

  // The last transfers may give no result, so the framer may still be busy when
  // the queue empties; the wait afterwards covers its two stages, input and output.
  task automatic drain_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_noack(input logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    write_noack(1'b0);

    foreach (dir_tab[i]) send_byte(dir_tab[i].rx, dir_tab[i].chk, dir_tab[i].want);

    drain_idle();
    write_noack(1'b1);
    tx_gap_max = 6;
    rx_idle_max = 6;
    random_phase(450);

    drain_idle();
    write_noack(1'b0);
    tx_gap_max = 0;
    rx_idle_max = 0;
    random_phase(450);

    // Sender runs flat out while the receiver holds off, so the input stalls.
    drain_idle();
    write_noack(1'b1);
    tx_gap_max = 0;
    rx_idle_max = 3;
    rx_hold_req = 1'b1;
    random_phase(450);

    drain_idle();
    write_noack(1'b0);
    tx_gap_max = 6;
    rx_idle_max = 6;
    random_phase(450);

    drain_idle();
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
